// ----- design/sgmf_pkg.sv -----
// Shared widths, reset values and cell control type for the spike-gated median filter.
package sgmf_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int JUMP_W     = 23;
  localparam int WINDOW_DEF = 10;

  localparam logic [JUMP_W-1:0] JUMP_LIMIT_RST = JUMP_W'(1000);

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic prime;   // fill every cell with the sample
    logic insert;  // oldest cell takes the sample, others age
    logic sort;    // one odd-even compare-exchange round
    logic phase;   // parity of the pairs that exchange this round
  } sgmf_ctrl_t;

endpackage

// ----- design/sgmf_cell.sv -----
// One window cell: holds a sample and its age, exchanges with a neighbor during sorting.
module sgmf_cell #(
  parameter int WINDOW   = sgmf_pkg::WINDOW_DEF,
  parameter int CELL_IDX = 0
) (
  input  logic                                  clk,
  input  sgmf_pkg::sgmf_ctrl_t                  ctrl,
  input  logic signed [sgmf_pkg::SAMPLE_W-1:0]  sample,
  input  logic signed [sgmf_pkg::SAMPLE_W-1:0]  left_val,
  input  logic [$clog2(WINDOW)-1:0]             left_age,
  input  logic signed [sgmf_pkg::SAMPLE_W-1:0]  right_val,
  input  logic [$clog2(WINDOW)-1:0]             right_age,
  output logic signed [sgmf_pkg::SAMPLE_W-1:0]  val,
  output logic [$clog2(WINDOW)-1:0]             age
);
  import sgmf_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam logic [AW-1:0] OLDEST   = AW'(WINDOW - 1);
  localparam logic [AW-1:0] INIT_AGE = AW'(CELL_IDX);
  localparam logic          PARITY   = 1'(CELL_IDX % 2);
  localparam logic          HAS_LEFT  = (CELL_IDX > 0);
  localparam logic          HAS_RIGHT = (CELL_IDX < WINDOW - 1);

  logic with_right;
  logic with_left;

  // pair (2k+p, 2k+p+1) exchanges in a round of phase p
  assign with_right = ctrl.sort && (PARITY == ctrl.phase) && HAS_RIGHT;
  assign with_left  = ctrl.sort && (PARITY != ctrl.phase) && HAS_LEFT;

  // value and age move together; lower cell keeps the smaller value
  always_ff @(posedge clk) begin
    if (ctrl.prime) begin
      val <= sample;
      age <= INIT_AGE;
    end else if (ctrl.insert) begin
      if (age == OLDEST) begin
        val <= sample;
        age <= '0;
      end else begin
        age <= age + AW'(1);
      end
    end else if (with_right && (val > right_val)) begin
      val <= right_val;
      age <= right_age;
    end else if (with_left && (left_val > val)) begin
      val <= left_val;
      age <= left_age;
    end
  end

endmodule

// ----- design/spike_gated_median_filter_core.sv -----
// Top level: spike gate, sequencer and the sorted chain of window cells.
//
//  channel   | handshake                | payload
//  ----------+--------------------------+-------------------------------
//  input     | in_valid / in_stall      | sample
//  output    | out_valid / out_stall    | filtered, rejected
//  config    | limit_we                 | limit_wdata
//
// An accepted sample inside the jump limit is handled in steps: the oldest cell
// loads it as the sample is taken, WINDOW odd-even exchange rounds run through
// the cell chain, and the median moves into the output register once it is free.
// The first sample and rejected samples skip the exchange rounds.
// Reset is synchronous and clears the sequencer, the primed flag, the output
// valid and the jump limit (back to 1000); the window is refilled by the first sample.
// in_stall is high while a word is in work; a stalled output word holds the
// sequencer in its done state, so it also blocks the acceptance of the next sample.
module spike_gated_median_filter_core #(
  parameter int WINDOW = sgmf_pkg::WINDOW_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sgmf_pkg::SAMPLE_W-1:0]  sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sgmf_pkg::SAMPLE_W-1:0]  filtered,
  output logic                                  rejected,
  input  logic                                  limit_we,
  input  logic [sgmf_pkg::JUMP_W-1:0]           limit_wdata
);
  import sgmf_pkg::*;

  localparam int AW = $clog2(WINDOW);
  localparam int RW = $clog2(WINDOW);
  localparam logic [RW-1:0] LAST_ROUND = RW'(WINDOW - 1);
  localparam int MID = WINDOW / 2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SORT,
    S_DONE
  } state_t;

  state_t                       state;
  logic [RW-1:0]                round;
  logic                         primed;
  logic                         from_sort;
  logic                         rej_flag;
  logic signed [SAMPLE_W-1:0]   held;
  logic [JUMP_W-1:0]            jump_limit;

  logic                         in_acc;
  logic                         out_free;
  logic signed [SAMPLE_W:0]     diff;
  logic [SAMPLE_W:0]            abs_diff;
  logic                         spike;
  logic signed [SAMPLE_W-1:0]   result;
  sgmf_ctrl_t                   ctrl;

  logic signed [SAMPLE_W-1:0]   cell_val [WINDOW];
  logic [AW-1:0]                cell_age [WINDOW];

  assign in_stall = (state != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // distance from the held value, exact at 25 bits
  assign diff     = {sample[SAMPLE_W-1], sample} - {held[SAMPLE_W-1], held};
  assign abs_diff = diff[SAMPLE_W] ? 25'(-diff) : 25'(diff);
  assign spike    = abs_diff > {2'b00, jump_limit};

  // median sits in the middle cell once the chain is sorted
  assign result = from_sort ? cell_val[MID] : held;

  // cell control
  always_comb begin
    ctrl.prime  = in_acc && !primed;
    ctrl.insert = in_acc && primed && !spike;
    ctrl.sort   = (state == S_SORT);
    ctrl.phase  = round[0];
  end

  // chain of cells, each wired to its two neighbors
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic signed [SAMPLE_W-1:0] lv;
    logic [AW-1:0]              la;
    logic signed [SAMPLE_W-1:0] rv;
    logic [AW-1:0]              ra;

    if (i == 0) begin : g_left_edge
      assign lv = '0;
      assign la = '0;
    end else begin : g_left
      assign lv = cell_val[i-1];
      assign la = cell_age[i-1];
    end

    if (i == WINDOW - 1) begin : g_right_edge
      assign rv = '0;
      assign ra = '0;
    end else begin : g_right
      assign rv = cell_val[i+1];
      assign ra = cell_age[i+1];
    end

    sgmf_cell #(
      .WINDOW   (WINDOW),
      .CELL_IDX (i)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .sample    (sample),
      .left_val  (lv),
      .left_age  (la),
      .right_val (rv),
      .right_age (ra),
      .val       (cell_val[i]),
      .age       (cell_age[i])
    );
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      jump_limit <= JUMP_LIMIT_RST;
    end else if (limit_we) begin
      jump_limit <= limit_wdata;
    end
  end

  // sequencer, held value and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      round     <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
      from_sort <= 1'b0;
      rej_flag  <= 1'b0;
    end else begin
      // output word: load when done and free, drop once taken
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            round <= '0;
            if (!primed) begin
              primed    <= 1'b1;
              held      <= sample;
              rej_flag  <= 1'b0;
              from_sort <= 1'b0;
              state     <= S_DONE;
            end else if (spike) begin
              rej_flag  <= 1'b1;
              from_sort <= 1'b0;
              state     <= S_DONE;
            end else begin
              rej_flag  <= 1'b0;
              from_sort <= 1'b1;
              state     <= S_SORT;
            end
          end
        end
        S_SORT: begin
          round <= round + RW'(1);
          if (round == LAST_ROUND) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            held      <= result;
            filtered  <= result;
            rejected  <= rej_flag;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/sgmf_checker.sv -----
// Port-level checks for the spike-gated median filter, bound to the top level.
module sgmf_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [sgmf_pkg::SAMPLE_W-1:0] filtered,
  input logic                                 rejected
);
  import sgmf_pkg::*;

  // no word comes out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // one word in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was taken");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(filtered) && $stable(rejected)))
    else $error("stalled output word changed");

endmodule

bind spike_gated_median_filter_core sgmf_checker u_sgmf_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .filtered  (filtered),
  .rejected  (rejected)
);

// ----- tb/median_filter_checker.sv -----
// Checker for the spike-gated median filter: predicts every result word and compares it.
module median_filter_checker (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  input  logic                                  in_stall,
  input  logic signed [sgmf_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  out_valid,
  input  logic                                  out_stall,
  input  logic signed [sgmf_pkg::SAMPLE_W-1:0]  filtered,
  input  logic                                  rejected,
  input  logic                                  limit_we,
  input  logic [sgmf_pkg::JUMP_W-1:0]           limit_wdata,
  output int                                    fail_count,
  output int                                    pending,
  output logic signed [sgmf_pkg::SAMPLE_W-1:0]  held_now
);
  import sgmf_pkg::*;

  localparam int WIN       = WINDOW_DEF;
  localparam int MAX_SHOWN = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] filtered;
    logic                       rejected;
  } filter_word_t;

  // predicted filter state
  logic signed [SAMPLE_W-1:0] window_hist [WIN];
  int unsigned                oldest_slot;
  logic signed [SAMPLE_W-1:0] held;
  logic                       primed;
  logic [JUMP_W-1:0]          jump_limit;

  filter_word_t               expected_words [$];

  assign held_now = held;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // upper median of the window: insertion sort of a copy, entry WIN/2
  function automatic logic signed [SAMPLE_W-1:0] window_median();
    logic signed [SAMPLE_W-1:0] work [WIN];
    logic signed [SAMPLE_W-1:0] key;
    int j;
    work = window_hist;
    for (int i = 1; i < WIN; i++) begin
      key = work[i];
      j = i - 1;
      while (j >= 0 && work[j] > key) begin
        work[j + 1] = work[j];
        j--;
      end
      work[j + 1] = key;
    end
    return work[WIN / 2];
  endfunction

  // advance the predicted state by one sample and give the word it returns
  task automatic filter_step(input logic signed [SAMPLE_W-1:0] s, output filter_word_t w);
    longint gap_mm;
    w.rejected = 1'b0;
    if (!primed) begin
      // first sample fills the whole window
      for (int i = 0; i < WIN; i++) window_hist[i] = s;
      held   = s;
      primed = 1'b1;
    end else begin
      gap_mm = longint'(s) - longint'(held);
      if (gap_mm < 0) gap_mm = -gap_mm;
      if (gap_mm > longint'(jump_limit)) begin
        w.rejected = 1'b1;
      end else begin
        window_hist[oldest_slot] = s;
        oldest_slot = (oldest_slot + 1) % WIN;
        held = window_median();
      end
    end
    w.filtered = held;
  endtask

  task automatic log_fault(input string what);
    fail_count++;
    if (fail_count <= MAX_SHOWN) $display("%0t: %s", $time, what);
  endtask

  always @(posedge clk) begin
    filter_word_t want;
    filter_word_t got;
    if (rst) begin
      for (int i = 0; i < WIN; i++) window_hist[i] = '0;
      oldest_slot = 0;
      held        = '0;
      primed      = 1'b0;
      jump_limit  = JUMP_LIMIT_RST;
      expected_words.delete();
    end else begin
      if (limit_we) jump_limit = limit_wdata;
      // results first: a word leaving now belongs to an earlier sample
      if (out_valid && !out_stall) begin
        got.filtered = filtered;
        got.rejected = rejected;
        if (expected_words.size() == 0) begin
          log_fault($sformatf("unexpected word: filtered=%0d rejected=%0b",
                              got.filtered, got.rejected));
        end else begin
          want = expected_words.pop_front();
          if (got.filtered !== want.filtered || got.rejected !== want.rejected)
            log_fault($sformatf("mismatch: filtered exp=%0d got=%0d, rejected exp=%0b got=%0b",
                                want.filtered, got.filtered, want.rejected, got.rejected));
        end
      end
      if (in_valid && !in_stall) begin
        filter_step(sample, want);
        expected_words.push_back(want);
      end
    end
    pending = expected_words.size();
  end

endmodule

// ----- tb/spike_gated_median_filter_core_test.sv -----
// Stimulus and verdict for the spike-gated median filter core.
module spike_gated_median_filter_core_test;
  import sgmf_pkg::*;

  localparam int     WIN          = WINDOW_DEF;
  localparam int     DRAIN_CYCLES = 4 * WIN + 8;
  localparam int     CYCLE_LIMIT  = 600000;
  localparam int     PHASE_WORDS  = 100;
  localparam int     PHASES       = 8;
  localparam longint SAMPLE_LO    = -(longint'(1) << (SAMPLE_W - 1));
  localparam longint SAMPLE_HI    = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = SAMPLE_LO[SAMPLE_W-1:0];
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = SAMPLE_HI[SAMPLE_W-1:0];
  localparam logic [JUMP_W-1:0]          JUMP_MAX   = '1;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_stall;
  logic signed [SAMPLE_W-1:0]  sample;
  logic                        out_valid;
  logic                        out_stall;
  logic signed [SAMPLE_W-1:0]  filtered;
  logic                        rejected;
  logic                        limit_we;
  logic [JUMP_W-1:0]           limit_wdata;

  int                          fail_count;
  int                          pending;
  logic signed [SAMPLE_W-1:0]  held_now;
  logic [JUMP_W-1:0]           jump_now;
  bit                          gaps_on;

  spike_gated_median_filter_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .filtered    (filtered),
    .rejected    (rejected),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata)
  );

  median_filter_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .filtered    (filtered),
    .rejected    (rejected),
    .limit_we    (limit_we),
    .limit_wdata (limit_wdata),
    .fail_count  (fail_count),
    .pending     (pending),
    .held_now    (held_now)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // samples mostly near the held value, some on the jump boundary, some anywhere
  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input logic [JUMP_W-1:0] lim);
    longint base;
    longint span;
    longint v;
    int     r;
    base = longint'(held_now);
    span = longint'(lim) + longint'(lim) / 4 + 2;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      v = base - span + longint'($urandom_range(0, 32'(2 * span)));
    end else if (r < 82) begin
      v = longint'(lim) + longint'($urandom_range(0, 1));
      if ($urandom_range(0, 1)) v = -v;
      v = base + v;
    end else begin
      return SAMPLE_W'($urandom);
    end
    if (v > SAMPLE_HI) v = SAMPLE_HI;
    if (v < SAMPLE_LO) v = SAMPLE_LO;
    return v[SAMPLE_W-1:0];
  endfunction

  // called at a falling edge; returns at a falling edge
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] s);
    int gap;
    in_valid <= 1'b1;
    sample   <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // stop sending and wait until every result is out and the core is quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_jump(input logic [JUMP_W-1:0] v);
    settle();
    limit_we    <= 1'b1;
    limit_wdata <= v;
    jump_now = v;
    @(negedge clk);
    limit_we <= 1'b0;
    @(negedge clk);
  endtask

  // result side back-pressure
  initial begin
    int run;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      run = pick_gap();
      if (run > 0) begin
        out_stall <= 1'b1;
        repeat (run) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("spike_gated_median_filter_core_test: FAIL");
    $finish;
  end

  initial begin
    logic [JUMP_W-1:0] lim;
    rst         = 1'b1;
    in_valid    = 1'b0;
    sample      = '0;
    limit_we    = 1'b0;
    limit_wdata = '0;
    gaps_on     = 1'b1;
    jump_now    = JUMP_LIMIT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: priming far from zero, boundaries at the reset limit
    send_sample(SAMPLE_MIN);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MIN + 24'sd1000);
    send_sample(SAMPLE_MIN + 24'sd1001);
    send_sample('0);

    // widest limit: one past it and exactly at it, then drag the median up
    set_jump(JUMP_MAX);
    send_sample('0);
    repeat (6) send_sample(-24'sd1);
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX - 24'sd1);

    // zero limit: only the held value itself gets in
    set_jump('0);
    send_sample(held_now);
    send_sample(held_now + 24'sd1);
    send_sample(held_now - 24'sd1);

    // random phases over a spread of limits
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       lim = 23'd1000;
        1:       lim = 23'd1;
        2:       lim = '0;
        3:       lim = 23'd37;
        4:       lim = JUMP_MAX;
        5:       lim = 23'd65536;
        default: lim = JUMP_W'($urandom_range(0, int'(JUMP_MAX)));
      endcase
      set_jump(lim);
      gaps_on = (p % 3 != 1);
      repeat (PHASE_WORDS) send_sample(pick_sample(jump_now));
    end

    settle();
    if (fail_count == 0) begin
      $display("spike_gated_median_filter_core_test: PASS");
    end else begin
      $display("spike_gated_median_filter_core_test: FAIL");
    end
    $finish;
  end

endmodule
